/* hdl/gnms_pkg.sv */
// Shared types, widths, codes and helpers for the greedy NMS box filter.
// Used by every module of the block but gnms_ram; depends on nothing.
package gnms_pkg;

  localparam int KEPT_DEPTH = 256;
  localparam int COORD_BITS = 16;
  localparam int CLASS_BITS = 8;

  localparam int SLOT_BITS  = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(KEPT_DEPTH + 1);

  // configuration register and output field widths are fixed
  localparam int CFG_BITS       = 9;
  localparam int CFG_IDX_BITS   = 2;
  localparam int VERDICT_BITS   = 2;
  localparam int OUT_SLOT_BITS  = 8;
  localparam int OUT_COUNT_BITS = 9;
  localparam int CMP_BITS       = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNI_BITS   = AREA_BITS + 1;
  localparam int PROD_BITS  = UNI_BITS + CFG_BITS;
  localparam int ENTRY_BITS = CLASS_BITS + AREA_BITS + 4 * COORD_BITS;

  localparam logic [VERDICT_BITS-1:0] VERDICT_KEPT       = 2'd0;
  localparam logic [VERDICT_BITS-1:0] VERDICT_SUPPRESSED = 2'd1;
  localparam logic [VERDICT_BITS-1:0] VERDICT_DROPPED    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_IOU_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_KEPT     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IGNORE_CLASS = 2'd2;

  localparam logic [CFG_BITS-1:0] IOU_LIMIT_RESET = 9'd179;
  localparam logic [CFG_BITS-1:0] MAX_KEPT_RESET  = 9'd256;

  typedef struct packed {
    logic                         frame_start;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic signed [COORD_BITS-1:0] box_right;
    logic signed [COORD_BITS-1:0] box_bottom;
    logic [CLASS_BITS-1:0]        box_class;
  } box_in_t;

  typedef struct packed {
    logic [VERDICT_BITS-1:0]   verdict;
    logic [OUT_SLOT_BITS-1:0]  kept_slot;
    logic [OUT_COUNT_BITS-1:0] kept_count;
  } box_out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic scan_done;
    logic pipe_empty;
  } ctrl_status_t;

  // positive side length, zero for empty or inverted spans
  function automatic logic [COORD_BITS-1:0] pos_len(
    input logic signed [COORD_BITS-1:0] hi,
    input logic signed [COORD_BITS-1:0] lo
  );
    logic signed [COORD_BITS:0] diff;
    diff = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
    if (diff > 0) begin
      return diff[COORD_BITS-1:0];
    end
    return '0;
  endfunction

endpackage

/* hdl/gnms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/gnms_ctrl.sv */
// Sequencer for the NMS filter: load, scan of the kept list, drain, finish.
// Depends on gnms_pkg for command and status structs.
module gnms_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  gnms_pkg::ctrl_status_t status,
  output gnms_pkg::ctrl_cmd_t    cmd
);
  import gnms_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = status.at_limit ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = rst | (state != ST_IDLE);

endmodule

/* hdl/gnms_datapath.sv */
// Datapath of the NMS filter: config registers, kept-box RAM, IoU pipeline,
// kept counter and result register. Depends on gnms_pkg and gnms_ram.
module gnms_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  gnms_pkg::ctrl_cmd_t                 cmd,
  output gnms_pkg::ctrl_status_t              status,
  input  gnms_pkg::box_in_t                   box,
  input  logic                                cfg_valid,
  input  logic [gnms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [gnms_pkg::CFG_BITS-1:0]       cfg_data,
  output logic                                result_valid,
  output gnms_pkg::box_out_t                  result
);
  import gnms_pkg::*;

  logic [CFG_BITS-1:0] iou_limit;
  logic [CFG_BITS-1:0] max_kept;
  logic                ignore_class;

  box_in_t             box_reg;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] addr;
  logic                hit;

  logic [COORD_BITS-1:0] cand_w, cand_h;
  logic [AREA_BITS-1:0]  cand_area;

  logic [CMP_BITS-1:0] limit;
  logic [CMP_BITS-1:0] max_ext;
  logic                at_limit;

  logic                  ram_we;
  logic [ENTRY_BITS-1:0] wr_entry, rd_entry;

  logic signed [COORD_BITS-1:0] s_left, s_top, s_right, s_bottom;
  logic [AREA_BITS-1:0]         s_area;
  logic [CLASS_BITS-1:0]        s_class;
  logic signed [COORD_BITS-1:0] ix1, iy1, ix2, iy2;

  // compare pipeline
  logic                  rd_v, v1, v2, v3, v4;
  logic                  m1, m2, m3, m4;
  logic [COORD_BITS-1:0] iw1, ih1;
  logic [AREA_BITS-1:0]  area1, area2;
  logic [AREA_BITS-1:0]  inter2, inter3;
  logic [UNI_BITS-1:0]   uni3;
  logic [PROD_BITS-1:0]  prod4, inter4;

  logic                     keep;
  logic [VERDICT_BITS-1:0]  verdict;

  assign max_ext  = CMP_BITS'(max_kept);
  assign limit    = (max_ext > CMP_BITS'(KEPT_DEPTH)) ? CMP_BITS'(KEPT_DEPTH) : max_ext;
  assign at_limit = CMP_BITS'(count) >= limit;

  assign status.at_limit   = at_limit;
  assign status.scan_done  = (addr == count);
  assign status.pipe_empty = !(rd_v | v1 | v2 | v3 | v4);

  assign keep    = !at_limit && !hit;
  assign verdict = at_limit ? VERDICT_DROPPED : (hit ? VERDICT_SUPPRESSED : VERDICT_KEPT);

  assign ram_we   = cmd.finish && keep;
  assign wr_entry = {box_reg.box_class, cand_area, box_reg.box_bottom, box_reg.box_right,
                     box_reg.box_top, box_reg.box_left};

  gnms_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (KEPT_DEPTH)
  ) u_kept_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[SLOT_BITS-1:0]),
    .wdata (wr_entry),
    .re    (cmd.issue),
    .raddr (addr[SLOT_BITS-1:0]),
    .rdata (rd_entry)
  );

  assign s_left   = $signed(rd_entry[COORD_BITS-1:0]);
  assign s_top    = $signed(rd_entry[2*COORD_BITS-1:COORD_BITS]);
  assign s_right  = $signed(rd_entry[3*COORD_BITS-1:2*COORD_BITS]);
  assign s_bottom = $signed(rd_entry[4*COORD_BITS-1:3*COORD_BITS]);
  assign s_area   = rd_entry[4*COORD_BITS+AREA_BITS-1:4*COORD_BITS];
  assign s_class  = rd_entry[ENTRY_BITS-1:4*COORD_BITS+AREA_BITS];

  assign ix1 = (box_reg.box_left   > s_left)   ? box_reg.box_left   : s_left;
  assign iy1 = (box_reg.box_top    > s_top)    ? box_reg.box_top    : s_top;
  assign ix2 = (box_reg.box_right  < s_right)  ? box_reg.box_right  : s_right;
  assign iy2 = (box_reg.box_bottom < s_bottom) ? box_reg.box_bottom : s_bottom;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_limit    <= IOU_LIMIT_RESET;
      max_kept     <= MAX_KEPT_RESET;
      ignore_class <= 1'b0;
      count        <= '0;
      addr         <= '0;
      hit          <= 1'b0;
      rd_v         <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IOU_LIMIT:    iou_limit    <= cfg_data;
          REG_MAX_KEPT:     max_kept     <= cfg_data;
          REG_IGNORE_CLASS: ignore_class <= cfg_data[0];
          default: ;
        endcase
      end
      rd_v <= cmd.issue;
      v1   <= rd_v;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      if (cmd.load) begin
        addr <= '0;
        hit  <= 1'b0;
        if (box.frame_start) begin
          count <= '0;
        end
      end else begin
        if (cmd.issue) begin
          addr <= addr + 1'b1;
        end
        if (v4 && m4 && (inter4 > prod4)) begin
          hit <= 1'b1;
        end
        if (ram_we) begin
          count <= count + 1'b1;
        end
      end
      result_valid <= cmd.finish;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_reg <= box;
    end
    cand_w    <= pos_len(box_reg.box_right, box_reg.box_left);
    cand_h    <= pos_len(box_reg.box_bottom, box_reg.box_top);
    cand_area <= AREA_BITS'(cand_w * cand_h);

    iw1   <= pos_len(ix2, ix1);
    ih1   <= pos_len(iy2, iy1);
    area1 <= s_area;
    m1    <= ignore_class || (s_class == box_reg.box_class);

    inter2 <= AREA_BITS'(iw1 * ih1);
    area2  <= area1;
    m2     <= m1;

    uni3   <= UNI_BITS'(cand_area) + UNI_BITS'(area2) - UNI_BITS'(inter2);
    inter3 <= inter2;
    m3     <= m2;

    prod4  <= PROD_BITS'(iou_limit * uni3);
    inter4 <= PROD_BITS'({inter3, 8'd0});
    m4     <= m3;

    if (cmd.finish) begin
      result.verdict    <= verdict;
      result.kept_slot  <= keep ? OUT_SLOT_BITS'(count) : '0;
      result.kept_count <= keep ? OUT_COUNT_BITS'(count + 1'b1) : OUT_COUNT_BITS'(count);
    end
  end

endmodule

/* hdl/greedy_nms_box_filter_unit.sv */
// Greedy NMS box filter, top level. One box at a time; the scan of the
// kept-box RAM, one entry per cycle over its single read port, sets the
// rate. Results cannot be stalled.
// Synchronous active-high reset restores iou_limit 179, max_kept 256,
// ignore_class 0 and an empty kept list; the kept-box RAM is not cleared.
module greedy_nms_box_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  // command side: a box is taken when start is high and busy is low
  input  logic                              start,
  output logic                              busy,
  input  gnms_pkg::box_in_t                 box,
  // one result word per box, valid for exactly one cycle
  output logic                              result_valid,
  output gnms_pkg::box_out_t                result,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gnms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [gnms_pkg::CFG_BITS-1:0]     cfg_data
);
  import gnms_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // accept config words any time out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ready <= 1'b0;
    end else begin
      cfg_ready <= 1'b1;
    end
  end

  // sequencer: load the box; unless the limit is reached, sweep the kept list
  // and wait for the compare pipeline to empty; then issue the verdict
  gnms_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: kept-box RAM, five-stage IoU compare, counter, result word
  gnms_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .box          (box),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* hdl/gnms_checker.sv */
// Port-level checks for the greedy NMS box filter, bound to the top level.
// Depends on gnms_pkg and greedy_nms_box_filter_unit.
module gnms_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                result_valid,
  input gnms_pkg::box_out_t  result
);
  import gnms_pkg::*;

  logic [OUT_COUNT_BITS-1:0] count_m1;

  assign count_m1 = result.kept_count - OUT_COUNT_BITS'(1);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a box was taken");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.verdict == VERDICT_KEPT) ||
                     (result.verdict == VERDICT_SUPPRESSED) ||
                     (result.verdict == VERDICT_DROPPED))
    else $error("illegal verdict code");

  a_kept_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.verdict == VERDICT_KEPT) |->
      (result.kept_count != '0) && (result.kept_slot == OUT_SLOT_BITS'(count_m1)))
    else $error("kept slot does not match kept count");

  a_other_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.verdict != VERDICT_KEPT) |-> (result.kept_slot == '0))
    else $error("slot nonzero for a box that was not kept");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word without a box in flight");

endmodule

bind greedy_nms_box_filter_unit gnms_checker u_gnms_checker (.*);
